/* hw/rtl/dhkt_pkg.sv */
// Package for the djb2 hashed key table: sizes, opcode and status codes,
// state machine type and the hash fold function.
// Depends on nothing; every other RTL file of the block uses it.
`default_nettype none

package dhkt_pkg;

    // Table size and derived widths
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Beat field widths
    localparam int OPCODE_W  = 2;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int ENTRY_W   = 6;
    localparam int USED_W    = 7;
    localparam int HASH_W    = 64;

    // Hash constants
    localparam logic [HASH_W-1:0] HASH_START = HASH_W'(5381);
    localparam int                HASH_SHIFT = 5;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    // Fold one key byte into the hash: h*33 + signed byte, zero adds nothing
    function automatic logic [HASH_W-1:0] fold_byte(
        input logic [HASH_W-1:0] h,
        input logic [BYTE_W-1:0] b
    );
        logic [HASH_W-1:0] sext;
        sext = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
        if (b == '0) begin
            return h;
        end
        return (h << HASH_SHIFT) + h + sext;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/dhkt_if.sv */
// Channel interfaces of the djb2 hashed key table: key beats in, results out.
// Depends on dhkt_pkg for the field widths.
`default_nettype none

interface dhkt_in_if;
    logic                           valid;
    logic                           ready;
    logic [dhkt_pkg::OPCODE_W-1:0]  opcode;
    logic [dhkt_pkg::BYTE_W-1:0]    key_byte;
    logic                           last_byte;

    modport source (output valid, output opcode, output key_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input opcode, input key_byte, input last_byte,
                    output ready);
endinterface

interface dhkt_out_if;
    logic                           valid;
    logic                           ready;
    logic [dhkt_pkg::STATUS_W-1:0]  status;
    logic [dhkt_pkg::ENTRY_W-1:0]   entry_index;
    logic [dhkt_pkg::HASH_W-1:0]    key_hash;
    logic [dhkt_pkg::USED_W-1:0]    entries_used;

    modport source (output valid, output status, output entry_index, output key_hash,
                    output entries_used, input ready);
    modport sink   (input valid, input status, input entry_index, input key_hash,
                    input entries_used, output ready);
endinterface

`default_nettype wire

/* hw/rtl/djb2_hashed_key_table_unit.sv */
// Insert, clear and find on an empty table give their result in the cycle after the last beat.
// Find scans the hash memory one slot per cycle, by registered read and compare; its result is
// registered after the compare that matches, or after the last stored entry is compared.
// Throughput: one key byte per cycle; none in a find scan, no last beat while a result waits.
// Reset: running hash back to 5381 and entry count to zero; the memory is not cleared.
// Depends on dhkt_pkg and the channel interfaces in dhkt_if.sv.
`default_nettype none

module djb2_hashed_key_table_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dhkt_in_if.sink     i_in,
    dhkt_out_if.source  o_out
);

    // Hash memory
    logic [dhkt_pkg::HASH_W-1:0] r_mem [dhkt_pkg::TABLE_DEPTH];
    logic [dhkt_pkg::HASH_W-1:0] r_rd_data;

    // Control state
    dhkt_pkg::t_state             r_state, n_state;
    logic [dhkt_pkg::HASH_W-1:0]  r_hash, n_hash;
    logic [dhkt_pkg::CNT_W-1:0]   r_count, n_count;
    logic [dhkt_pkg::CNT_W-1:0]   r_rd_cnt, n_rd_cnt;
    logic                         r_cmp_vld;
    logic [dhkt_pkg::IDX_W-1:0]   r_cmp_idx;
    logic [dhkt_pkg::HASH_W-1:0]  r_key_hash;
    logic                         r_out_valid, n_out_valid;

    // Result payload
    logic [dhkt_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [dhkt_pkg::ENTRY_W-1:0]  r_out_index, n_out_index;
    logic [dhkt_pkg::HASH_W-1:0]   r_out_hash, n_out_hash;
    logic [dhkt_pkg::USED_W-1:0]   r_out_used, n_out_used;

    // Control signals
    logic                         in_ready;
    logic                         beat_acc;
    logic                         key_done;
    logic [dhkt_pkg::HASH_W-1:0]  folded;
    logic                         table_full;
    logic                         mem_we;
    logic                         scan_start;
    logic                         scan_hit;
    logic                         scan_end;
    logic                         scan_done;
    logic                         rd_issue;
    logic                         out_load;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dhkt_pkg::S_IDLE: begin
                if (scan_start) begin
                    n_state = dhkt_pkg::S_SCAN;
                end
            end
            dhkt_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = dhkt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dhkt_pkg::S_IDLE;
            end
        endcase
    end

    // Decode beats, steer the scan
    always_comb begin
        in_ready   = (r_state == dhkt_pkg::S_IDLE) &&
                     (!i_in.last_byte || !r_out_valid || o_out.ready);
        beat_acc   = i_in.valid && in_ready;
        key_done   = beat_acc && i_in.last_byte;
        folded     = dhkt_pkg::fold_byte(r_hash, i_in.key_byte);
        table_full = (r_count >= dhkt_pkg::CNT_W'(dhkt_pkg::TABLE_DEPTH));
        mem_we     = key_done && (i_in.opcode == dhkt_pkg::OP_INSERT) && !table_full;
        scan_start = key_done && (i_in.opcode == dhkt_pkg::OP_FIND) && (r_count != '0);
        scan_hit   = r_cmp_vld && (r_rd_data == r_key_hash);
        scan_end   = r_cmp_vld &&
                     ((dhkt_pkg::CNT_W'(r_cmp_idx) + dhkt_pkg::CNT_W'(1)) == r_count);
        scan_done  = (r_state == dhkt_pkg::S_SCAN) && (scan_hit || scan_end);
        rd_issue   = (r_state == dhkt_pkg::S_SCAN) && !scan_done && (r_rd_cnt < r_count);
    end

    // Running hash, entry count and scan counter
    always_comb begin
        n_hash   = r_hash;
        n_count  = r_count;
        n_rd_cnt = r_rd_cnt;
        if (beat_acc) begin
            n_hash = i_in.last_byte ? dhkt_pkg::HASH_START : folded;
        end
        if (mem_we) begin
            n_count = r_count + dhkt_pkg::CNT_W'(1);
        end else if (key_done && (i_in.opcode == dhkt_pkg::OP_CLEAR)) begin
            n_count = '0;
        end
        if (scan_start) begin
            n_rd_cnt = '0;
        end else if (rd_issue) begin
            n_rd_cnt = r_rd_cnt + dhkt_pkg::CNT_W'(1);
        end
    end

    // Build the result beat
    always_comb begin
        out_load     = 1'b0;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        n_out_hash   = r_out_hash;
        n_out_used   = r_out_used;
        if (scan_done) begin
            out_load     = 1'b1;
            n_out_status = scan_hit ? dhkt_pkg::ST_FOUND : dhkt_pkg::ST_NOT_FOUND;
            n_out_index  = scan_hit ? dhkt_pkg::ENTRY_W'(r_cmp_idx) : '0;
            n_out_hash   = r_key_hash;
            n_out_used   = dhkt_pkg::USED_W'(r_count);
        end else if (key_done) begin
            n_out_hash  = folded;
            n_out_index = '0;
            n_out_used  = dhkt_pkg::USED_W'(r_count);
            case (i_in.opcode)
                dhkt_pkg::OP_INSERT: begin
                    out_load = 1'b1;
                    if (table_full) begin
                        n_out_status = dhkt_pkg::ST_FULL;
                    end else begin
                        n_out_status = dhkt_pkg::ST_INSERTED;
                        n_out_index  = dhkt_pkg::ENTRY_W'(r_count);
                        n_out_used   = dhkt_pkg::USED_W'(r_count + dhkt_pkg::CNT_W'(1));
                    end
                end
                dhkt_pkg::OP_FIND: begin
                    // Empty table answers at once, otherwise the scan answers
                    out_load     = (r_count == '0);
                    n_out_status = dhkt_pkg::ST_NOT_FOUND;
                end
                dhkt_pkg::OP_CLEAR: begin
                    out_load     = 1'b1;
                    n_out_status = dhkt_pkg::ST_CLEARED;
                    n_out_used   = '0;
                end
                default: begin
                    out_load = 1'b0;
                end
            endcase
        end
        n_out_valid = out_load || (r_out_valid && !o_out.ready);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dhkt_pkg::S_IDLE;
            r_hash      <= dhkt_pkg::HASH_START;
            r_count     <= '0;
            r_rd_cnt    <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_count     <= n_count;
            r_rd_cnt    <= n_rd_cnt;
            r_cmp_vld   <= rd_issue;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_rd_cnt[dhkt_pkg::IDX_W-1:0];
        if (scan_start) begin
            r_key_hash <= folded;
        end
        if (out_load) begin
            r_out_status <= n_out_status;
            r_out_index  <= n_out_index;
            r_out_hash   <= n_out_hash;
            r_out_used   <= n_out_used;
        end
    end

    // Hash memory: write on insert, registered read during a scan
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[dhkt_pkg::IDX_W-1:0]] <= folded;
        end
        if (rd_issue) begin
            r_rd_data <= r_mem[r_rd_cnt[dhkt_pkg::IDX_W-1:0]];
        end
    end

    // Drive the channels
    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.entry_index  = r_out_index;
    assign o_out.key_hash     = r_out_hash;
    assign o_out.entries_used = r_out_used;

    // Entry count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dhkt_pkg::CNT_W'(dhkt_pkg::TABLE_DEPTH))
        else $error("entry count above table depth");

    // No table write while a scan reads it
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> r_state == dhkt_pkg::S_IDLE)
        else $error("table write during scan");

    // A compare slot only exists inside a scan
    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> r_state == dhkt_pkg::S_SCAN)
        else $error("compare outside scan");

    // A find on a non-empty table enters the scan with no compare slot yet
    a_find_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_start |=> (r_state == dhkt_pkg::S_SCAN) && !r_cmp_vld)
        else $error("find did not start scan");

    // A scan never reads past the stored entries
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> dhkt_pkg::CNT_W'(r_cmp_idx) < r_count)
        else $error("scan read beyond stored entries");

endmodule

`default_nettype wire

/* bench/djb2_hashed_key_table_unit_tb.sv */
// Self-checking bench for djb2_hashed_key_table_unit: key beats go in, table results are
// scored against a local model of the hash fold and the slot table.
// Depends on dhkt_pkg and the channel interfaces in dhkt_if.sv.
`timescale 1ns / 100ps

module djb2_hashed_key_table_unit_tb;

    // Opcode that the block drops without a result
    localparam logic [dhkt_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [dhkt_pkg::STATUS_W-1:0] status;
        logic [dhkt_pkg::ENTRY_W-1:0]  entry_index;
        logic [dhkt_pkg::HASH_W-1:0]   key_hash;
        logic [dhkt_pkg::USED_W-1:0]   entries_used;
    } t_key_result;

    logic clk;
    logic rst_n;

    dhkt_in_if  key_in ();
    dhkt_out_if res_out ();

    djb2_hashed_key_table_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (key_in),
        .o_out   (res_out)
    );

    // Model state: hash being folded, stored slot hashes, fill level
    logic [dhkt_pkg::HASH_W-1:0] key_acc_hash;
    logic [dhkt_pkg::HASH_W-1:0] table_hashes [0:dhkt_pkg::TABLE_DEPTH-1];
    int                          table_fill;
    t_key_result                 pending_results [$];

    // Key bytes behind each slot, so that finds can replay stored keys
    logic [63:0] stored_key_bytes [0:dhkt_pkg::TABLE_DEPTH-1];
    int          stored_key_len   [0:dhkt_pkg::TABLE_DEPTH-1];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int beats_sent;
    int mismatch_count;

    // Clock: 8 ns period
    initial clk = 1'b0;
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop on a hung run
    initial begin
        #(5_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Fold one accepted beat into the model and queue the result it causes
    task automatic predict_key_beat(input logic [dhkt_pkg::OPCODE_W-1:0] op,
                                    input logic [dhkt_pkg::BYTE_W-1:0] kb,
                                    input logic lb);
        t_key_result                 res;
        logic [dhkt_pkg::HASH_W-1:0] done_hash;
        logic                        hit;
        if (kb != 8'h00) begin
            key_acc_hash = key_acc_hash * 64'd33 +
                           {{(dhkt_pkg::HASH_W-dhkt_pkg::BYTE_W){kb[dhkt_pkg::BYTE_W-1]}}, kb};
        end
        if (lb) begin
            done_hash        = key_acc_hash;
            key_acc_hash     = dhkt_pkg::HASH_START;
            res.key_hash     = done_hash;
            res.entry_index  = '0;
            res.status       = dhkt_pkg::ST_CLEARED;
            case (op)
                dhkt_pkg::OP_INSERT: begin
                    if (table_fill >= dhkt_pkg::TABLE_DEPTH) begin
                        res.status = dhkt_pkg::ST_FULL;
                    end else begin
                        res.entry_index          = dhkt_pkg::ENTRY_W'(table_fill);
                        table_hashes[table_fill] = done_hash;
                        table_fill++;
                        res.status = dhkt_pkg::ST_INSERTED;
                    end
                end
                dhkt_pkg::OP_FIND: begin
                    hit        = 1'b0;
                    res.status = dhkt_pkg::ST_NOT_FOUND;
                    for (int s = 0; s < table_fill; s++) begin
                        if (!hit && table_hashes[s] == done_hash) begin
                            hit             = 1'b1;
                            res.entry_index = dhkt_pkg::ENTRY_W'(s);
                            res.status      = dhkt_pkg::ST_FOUND;
                        end
                    end
                end
                dhkt_pkg::OP_CLEAR: begin
                    table_fill = 0;
                    res.status = dhkt_pkg::ST_CLEARED;
                end
                default: begin
                end
            endcase
            if (op != OP_UNUSED) begin
                res.entries_used = dhkt_pkg::USED_W'(table_fill);
                pending_results.push_back(res);
            end
        end
    endtask

    // Offer one beat, with random gaps ahead of it, and hold it until taken
    task automatic send_key_beat(input logic [dhkt_pkg::OPCODE_W-1:0] op,
                                 input logic [dhkt_pkg::BYTE_W-1:0] kb,
                                 input logic lb);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            key_in.valid     = 1'b0;
            key_in.opcode    = dhkt_pkg::OPCODE_W'($urandom_range(0, 3));
            key_in.key_byte  = dhkt_pkg::BYTE_W'($urandom_range(0, 255));
            key_in.last_byte = 1'($urandom_range(0, 1));
            @(negedge clk);
        end
        key_in.valid     = 1'b1;
        key_in.opcode    = op;
        key_in.key_byte  = kb;
        key_in.last_byte = lb;
        @(posedge clk);
        while (!key_in.ready) begin
            @(posedge clk);
        end
        beats_sent++;
        predict_key_beat(op, kb, lb);
    endtask

    // Send a whole key, first byte in the low bits; the opcode counts on the last beat only
    task automatic send_key(input logic [dhkt_pkg::OPCODE_W-1:0] op, input logic [63:0] kb,
                            input int len);
        for (int i = 0; i < len; i++) begin
            if (i == len - 1) begin
                send_key_beat(op, kb[8*i +: 8], 1'b1);
            end else begin
                send_key_beat(dhkt_pkg::OPCODE_W'($urandom_range(0, 3)), kb[8*i +: 8], 1'b0);
            end
        end
    endtask

    task automatic insert_key(input logic [63:0] kb, input int len);
        if (table_fill < dhkt_pkg::TABLE_DEPTH) begin
            stored_key_bytes[table_fill] = kb;
            stored_key_len[table_fill]   = len;
        end
        send_key(dhkt_pkg::OP_INSERT, kb, len);
    endtask

    // Idle the input and wait for every queued result, then a few quiet cycles
    task automatic drain_results();
        @(negedge clk);
        key_in.valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_key_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return 8'h00;
        end else if (r < 30) begin
            return 8'($urandom_range(128, 255));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [63:0] pick_key(input int len);
        logic [63:0] k;
        k = '0;
        for (int i = 0; i < len; i++) begin
            k[8*i +: 8] = pick_key_byte();
        end
        return k;
    endfunction

    // Receiver: long hold-off when asked, else random stalls
    always @(negedge clk) begin
        if (!rst_n) begin
            res_out.ready = 1'b0;
        end else if (hold_left > 0) begin
            res_out.ready = 1'b0;
            hold_left--;
        end else begin
            res_out.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Score each result beat against the oldest expectation
    always @(posedge clk) begin
        t_key_result want;
        if (rst_n && res_out.valid && res_out.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", res_out.key_hash, '0);
            end else begin
                want = pending_results.pop_front();
                if (res_out.status !== want.status) begin
                    report_mismatch("status", 64'(res_out.status), 64'(want.status));
                end
                if (res_out.entry_index !== want.entry_index) begin
                    report_mismatch("entry_index", 64'(res_out.entry_index),
                                    64'(want.entry_index));
                end
                if (res_out.key_hash !== want.key_hash) begin
                    report_mismatch("key_hash", res_out.key_hash, want.key_hash);
                end
                if (res_out.entries_used !== want.entries_used) begin
                    report_mismatch("entries_used", 64'(res_out.entries_used),
                                    64'(want.entries_used));
                end
            end
        end
    end

    // Empty table, signed byte extremes, zero bytes, duplicates, dropped key, clear
    task automatic test_directed_cases();
        send_key(dhkt_pkg::OP_FIND, 64'h41, 1);
        insert_key(64'h00, 1);
        insert_key(64'h7f, 1);
        insert_key(64'h80, 1);
        insert_key(64'hff, 1);
        insert_key(64'h020001, 3);
        send_key(dhkt_pkg::OP_FIND, 64'h0201, 2);
        send_key(dhkt_pkg::OP_FIND, 64'h0000, 2);
        insert_key(64'h7f, 1);
        send_key(dhkt_pkg::OP_FIND, 64'h7f, 1);
        send_key(OP_UNUSED, 64'h6655, 2);
        send_key(dhkt_pkg::OP_FIND, 64'hff00, 2);
        send_key(dhkt_pkg::OP_CLEAR, 64'h12, 1);
        send_key(dhkt_pkg::OP_FIND, 64'h7f, 1);
        insert_key(64'h7f80ffaa, 4);
    endtask

    // Fill every slot, overflow it, scan to the last slot and past the end
    task automatic test_table_full();
        send_key(dhkt_pkg::OP_CLEAR, 64'h00, 1);
        for (int s = 0; s < dhkt_pkg::TABLE_DEPTH; s++) begin
            insert_key(64'(s + 1), 1);
        end
        insert_key(64'h99, 1);
        send_key(dhkt_pkg::OP_FIND, 64'(dhkt_pkg::TABLE_DEPTH), 1);
        send_key(dhkt_pkg::OP_FIND, 64'hc0, 1);
        send_key(dhkt_pkg::OP_CLEAR, 64'h00, 1);
    endtask

    // Mostly well-formed keys with random content, some dropped keys and loose beats
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_beats);
        int          start_beats;
        int          r;
        int          len;
        int          slot;
        int          pos;
        logic [63:0] kb;
        logic [63:0] low_part;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_beats   = beats_sent;
        while (beats_sent - start_beats < n_beats) begin
            r   = $urandom_range(0, 99);
            len = $urandom_range(1, 6);
            kb  = pick_key(len);
            if (r < 40) begin
                insert_key(kb, len);
            end else if (r < 62 && table_fill > 0) begin
                slot = $urandom_range(0, table_fill - 1);
                kb   = stored_key_bytes[slot];
                len  = stored_key_len[slot];
                // Slip a zero byte in now and then: it must not change the hash
                if ($urandom_range(0, 3) == 0) begin
                    pos      = $urandom_range(0, len);
                    low_part = kb & ((64'd1 << (8 * pos)) - 64'd1);
                    kb       = low_part | ((kb >> (8 * pos)) << (8 * (pos + 1)));
                    len++;
                end
                send_key(dhkt_pkg::OP_FIND, kb, len);
            end else if (r < 77) begin
                send_key(dhkt_pkg::OP_FIND, kb, len);
            end else if (r < 80) begin
                send_key(dhkt_pkg::OP_CLEAR, kb, len);
            end else if (r < 87) begin
                send_key(OP_UNUSED, kb, len);
            end else begin
                send_key_beat(dhkt_pkg::OPCODE_W'($urandom_range(0, 3)), pick_key_byte(),
                              ($urandom_range(0, 3) == 0));
            end
        end
    endtask

    // Hold the result side off while keys keep coming, so the block backs up
    task automatic test_output_hold_off();
        send_idle_pct = 0;
        recv_idle_pct = 20;
        hold_left     = 160;
        for (int k = 0; k < 12; k++) begin
            insert_key(pick_key(2), 2);
        end
        send_key(dhkt_pkg::OP_FIND, stored_key_bytes[0], stored_key_len[0]);
        drain_results();
    endtask

    initial begin
        rst_n            = 1'b0;
        key_in.valid     = 1'b0;
        key_in.opcode    = dhkt_pkg::OP_INSERT;
        key_in.key_byte  = '0;
        key_in.last_byte = 1'b0;
        res_out.ready    = 1'b0;
        key_acc_hash     = dhkt_pkg::HASH_START;
        table_fill       = 0;
        send_idle_pct    = 10;
        recv_idle_pct    = 68;
        hold_left        = 0;
        beats_sent       = 0;
        mismatch_count   = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_table_full();
        drain_results();
        test_random_traffic(10, 68, 210);
        drain_results();
        test_random_traffic(68, 10, 210);
        drain_results();
        test_random_traffic(0, 0, 210);
        drain_results();
        test_output_hold_off();

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
